// ----- rtl/tvr_pkg.sv -----
`timescale 1ns / 1ps

package tvr_pkg;

  localparam int unsigned SineDepthDefault = 256;
  localparam longint unsigned PiQ30 = 64'd3373259426;

  localparam int unsigned DivSteps = 34;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // floor(x / 100) equals (x * Div100Recip) >> Div100Shift for every x below 2^24.
  localparam int unsigned Div100Recip = 21474837;
  localparam int unsigned Div100Shift = 31;

  typedef enum logic [1:0] {
    FUNC_SET  = 2'd0,
    FUNC_JUMP = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CURVE_KEEP     = 2'd0,
    CURVE_LINEAR   = 2'd1,
    CURVE_EASE_OUT = 2'd2,
    CURVE_EASE_IN  = 2'd3
  } curve_e;

  typedef enum logic [1:0] {
    CFG_PRECISION = 2'd0,
    CFG_RAMP      = 2'd1,
    CFG_FRAME     = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LMUL,
    ST_LDIV,
    ST_PHDIV,
    ST_PHASE,
    ST_IDX,
    ST_INTERP,
    ST_SCALE,
    ST_PROD,
    ST_APPLY,
    ST_POST,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic signed [25:0] a;
    logic signed [17:0] b;
  } mul_req_t;

endpackage

// ----- rtl/tvr_div.sv -----
`timescale 1ns / 1ps

module tvr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tvr_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [33:0]       quot_o
);
  import tvr_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] shifted;
  logic [33:0] trial;

  always_comb begin
    shifted = {rem_q[31:0], dvd_q[33]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // Restoring step: keep the difference when it did not go negative.
      if (!trial[33]) begin
        rem_d = trial[32:0];
        dvd_d = {dvd_q[32:0], 1'b1};
      end else begin
        rem_d = shifted;
        dvd_d = {dvd_q[32:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- rtl/tvr_mul.sv -----
`timescale 1ns / 1ps

module tvr_mul (
  input  logic                clk_i,
  input  tvr_pkg::mul_req_t   req_i,
  output logic signed [43:0]  prod_o
);
  import tvr_pkg::*;

  logic signed [43:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 44'(req_i.a) * 44'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/tvr_sine_rom.sv -----
`timescale 1ns / 1ps

module tvr_sine_rom #(
  parameter int unsigned DEPTH = tvr_pkg::SineDepthDefault,
  parameter int unsigned IW    = $clog2(DEPTH + 1)
) (
  input  logic [IW-1:0] addr_a_i,
  input  logic [IW-1:0] addr_b_i,
  output logic [16:0]   data_a_o,
  output logic [16:0]   data_b_o
);
  import tvr_pkg::*;

  logic [16:0] sine_tab [DEPTH+1];

  // Each entry is a truncated Taylor series of sin(x) in Q30, rounded to Q16.
  for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
    localparam longint unsigned X  = (PiQ30 * longint'(g)) / (2 * longint'(DEPTH));
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint unsigned T8 = ((T7 * X2) >> 30) / 272;
    localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6)
                             - longint'(T7) + longint'(T8);
    localparam longint CLIP = (SUM < 0) ? 64'sd0 : SUM;
    localparam longint RND  = (CLIP + 8192) / 16384;
    localparam longint VAL  = (RND > 65536) ? 64'sd65536 : RND;
    assign sine_tab[g] = 17'(VAL);
  end

  assign data_a_o = sine_tab[addr_a_i];
  assign data_b_o = sine_tab[addr_b_i];

endmodule

// ----- rtl/timed_value_ramp_with_easing.sv -----
`timescale 1ns / 1ps

// Timed value ramp with easing.
// Input stream: each request carries a command (tuser[1:0]: set target, jump,
// frame tick), a curve select (tuser[3:2]) and in tdata the new value and the
// current millisecond time. Every request yields exactly one result on the
// output stream: the milliseconds left and the current value in user units.
// Configuration writes (precision mode, ramp period, frame period) go through
// the cfg channel, which is always ready, and must be made while idle.
// Set, jump and ticks that hold or snap the value go from exec to post. A
// linear tick uses a multiply and the 34-step shared radix-2 divider; a sine
// tick divides for its phase unless the span is at least the ramp period,
// then interpolates the table. In precision mode the divide by 100 is a
// reciprocal multiply in the post step. One request is processed at a time;
// tready is low until the result has been placed in the output register.
// When the receiver stalls, the result waits in the output register and the
// block holds its last sequencer state until the register frees up.
// Reset clears the value state to zero, the curve to linear, the ramp period
// to 1000 ms and the frame period to 20 ms.
module timed_value_ramp_with_easing #(
  parameter int unsigned SINE_TABLE_DEPTH = tvr_pkg::SineDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,  // new_value, now_ms
  input  logic [3:0]                   s_axis_tuser,  // func, curve_select
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // remaining_ms, value
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tvr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tvr_pkg::CfgDataW-1:0] cfg_data_i
);
  import tvr_pkg::*;

  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);

  state_e state_q, state_d;

  logic               prec_q, prec_d;
  logic [15:0]        ramp_q, ramp_d;
  logic [7:0]         frame_q, frame_d;

  func_e              func_q;
  curve_e             sel_q;
  logic signed [15:0] val_q;
  logic [31:0]        now_q;

  logic signed [23:0] cur_q, cur_d, start_q, start_d, tgt_q, tgt_d;
  logic [31:0]        dl_q, dl_d;
  curve_e             curve_q, curve_d;

  logic [31:0]        d_q, d_d;
  logic [15:0]        res_q, res_d;
  logic               lneg_q, lneg_d;
  logic [16:0]        phase_q, phase_d;
  logic [16:0]        sa_q, sa_d, sd_q, sd_d, s_q, s_d;
  logic [15:0]        frac_q, frac_d;
  logic [17:0]        q100_q, q100_d;

  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_data_q, out_data_d;

  div_req_t           div_req;
  logic               div_done;
  logic [33:0]        div_quot;
  mul_req_t           mul_req;
  logic signed [43:0] mul_p;

  logic [IW-1:0]      rom_a, rom_b;
  logic [16:0]        rom_da, rom_db;

  logic               in_fire, out_free;
  logic signed [23:0] val_ext, scaled_in;
  logic signed [24:0] diff_tc, diff_ts;
  logic [31:0]        rem, span;
  logic [43:0]        p_mag;
  logic [24:0]        lin_q, prod_r;
  logic signed [24:0] lin_step, prod_s, out_v;
  logic [16:0]        ph;
  logic [IW-1:0]      idx;
  logic               idx_top;
  logic [23:0]        cur_mag;
  logic [48:0]        recip_p;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign val_ext   = {{8{val_q[15]}}, val_q};
  assign scaled_in = prec_q ? 24'(val_ext * 24'sd100) : val_ext;
  assign diff_tc   = {tgt_q[23], tgt_q} - {cur_q[23], cur_q};
  assign diff_ts   = {tgt_q[23], tgt_q} - {start_q[23], start_q};
  assign rem       = dl_q - now_q - 32'(frame_q);
  assign span      = rem + 32'(frame_q);
  assign p_mag     = mul_p[43] ? 44'(-mul_p) : 44'(mul_p);
  assign lin_q     = div_quot[24:0];
  assign lin_step  = lneg_q ? -$signed(lin_q) : $signed(lin_q);
  assign prod_r    = p_mag[40:16];
  assign prod_s    = mul_p[43] ? -$signed(prod_r) : $signed(prod_r);
  assign ph        = (curve_q == CURVE_EASE_OUT) ? 17'h10000 - phase_q : phase_q;
  assign idx       = mul_p[16 +: IW];
  assign idx_top   = 32'(idx) >= SINE_TABLE_DEPTH;
  assign rom_a     = idx_top ? IW'(SINE_TABLE_DEPTH) : idx;
  assign rom_b     = idx_top ? IW'(SINE_TABLE_DEPTH) : idx + IW'(1);
  assign cur_mag   = cur_q[23] ? 24'(-cur_q) : 24'(cur_q);
  assign recip_p   = 49'(cur_mag) * 49'(Div100Recip);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_EXEC;
      ST_EXEC: begin
        if (func_q != FUNC_TICK || tgt_q == cur_q || rem == 32'd0 || rem[31]) begin
          state_d = ST_POST;
        end else if (curve_q == CURVE_EASE_OUT || curve_q == CURVE_EASE_IN) begin
          state_d = (ramp_q == 16'd0 || span >= 32'(ramp_q)) ? ST_PHASE : ST_PHDIV;
        end else begin
          state_d = ST_LMUL;
        end
      end
      ST_LMUL:   state_d = ST_LDIV;
      ST_LDIV:   if (div_done) state_d = ST_POST;
      ST_PHDIV:  if (div_done) state_d = ST_PHASE;
      ST_PHASE:  state_d = ST_IDX;
      ST_IDX:    state_d = ST_INTERP;
      ST_INTERP: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_PROD;
      ST_PROD:   state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_POST;
      ST_POST:   state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    prec_d      = prec_q;
    ramp_d      = ramp_q;
    frame_d     = frame_q;
    cur_d       = cur_q;
    start_d     = start_q;
    tgt_d       = tgt_q;
    dl_d        = dl_q;
    curve_d     = curve_q;
    d_d         = d_q;
    res_d       = res_q;
    lneg_d      = lneg_q;
    phase_d     = phase_q;
    sa_d        = sa_q;
    sd_d        = sd_q;
    s_d         = s_q;
    frac_d      = frac_q;
    q100_d      = q100_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_req     = '0;
    mul_req     = '0;
    out_v       = '0;

    if (m_axis_tready) out_valid_d = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PRECISION: prec_d  = cfg_data_i[0];
        CFG_RAMP:      ramp_d  = cfg_data_i;
        CFG_FRAME:     frame_d = cfg_data_i[7:0];
        default:       ;
      endcase
    end

    unique case (state_q)
      ST_EXEC: begin
        res_d = '0;
        d_d   = span;
        unique case (func_q)
          FUNC_SET: begin
            if (sel_q != CURVE_KEEP) curve_d = sel_q;
            start_d = cur_q;
            tgt_d   = scaled_in;
            dl_d    = now_q + 32'(ramp_q);
          end
          FUNC_JUMP: begin
            start_d = scaled_in;
            cur_d   = scaled_in;
            tgt_d   = scaled_in;
          end
          FUNC_TICK: begin
            if (tgt_q != cur_q) begin
              if (rem == 32'd0 || rem[31]) begin
                cur_d = tgt_q;
                res_d = 16'd1;
              end else begin
                res_d = (rem > 32'hFFFF) ? 16'hFFFF : rem[15:0];
                phase_d = 17'h10000;
                if (curve_q == CURVE_EASE_OUT || curve_q == CURVE_EASE_IN) begin
                  if (!(ramp_q == 16'd0 || span >= 32'(ramp_q))) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {2'b00, span[15:0], 16'h0000};
                    div_req.divisor  = 32'(ramp_q);
                  end
                end else begin
                  mul_req.a = {diff_tc[24], diff_tc};
                  mul_req.b = {10'b0, frame_q};
                end
              end
            end
          end
          default: ;
        endcase
      end
      ST_LMUL: begin
        lneg_d           = mul_p[43];
        div_req.start    = 1'b1;
        div_req.dividend = p_mag[33:0];
        div_req.divisor  = d_q;
      end
      ST_LDIV:  if (div_done) cur_d = cur_q + lin_step[23:0];
      ST_PHDIV: if (div_done) phase_d = div_quot[16:0];
      ST_PHASE: begin
        mul_req.a = {9'b0, ph};
        mul_req.b = 18'(SINE_TABLE_DEPTH);
      end
      ST_IDX: begin
        sa_d   = rom_da;
        sd_d   = rom_db - rom_da;
        frac_d = idx_top ? 16'h0000 : mul_p[15:0];
      end
      ST_INTERP: begin
        mul_req.a = {10'b0, frac_q};
        mul_req.b = {1'b0, sd_q};
      end
      ST_SCALE: s_d = sa_q + mul_p[32:16];
      ST_PROD: begin
        mul_req.a = {diff_ts[24], diff_ts};
        mul_req.b = {1'b0, s_q};
      end
      ST_APPLY: begin
        if (curve_q == CURVE_EASE_OUT) cur_d = start_q + prod_s[23:0];
        else cur_d = tgt_q - prod_s[23:0];
      end
      ST_POST: q100_d = recip_p[Div100Shift +: 18];
      ST_FIN: begin
        if (prec_q) out_v = cur_q[23] ? -$signed({7'b0, q100_q}) : $signed({7'b0, q100_q});
        else out_v = {cur_q[23], cur_q};
        if (out_free) begin
          out_valid_d = 1'b1;
          if (out_v > 25'sd32767) out_data_d = {16'h7FFF, res_q};
          else if (out_v < -25'sd32768) out_data_d = {16'h8000, res_q};
          else out_data_d = {out_v[15:0], res_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prec_q      <= 1'b0;
      ramp_q      <= 16'd1000;
      frame_q     <= 8'd20;
      cur_q       <= '0;
      start_q     <= '0;
      tgt_q       <= '0;
      dl_q        <= '0;
      curve_q     <= CURVE_LINEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prec_q      <= prec_d;
      ramp_q      <= ramp_d;
      frame_q     <= frame_d;
      cur_q       <= cur_d;
      start_q     <= start_d;
      tgt_q       <= tgt_d;
      dl_q        <= dl_d;
      curve_q     <= curve_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_e'(s_axis_tuser[1:0]);
      sel_q  <= curve_e'(s_axis_tuser[3:2]);
      val_q  <= s_axis_tdata[15:0];
      now_q  <= s_axis_tdata[47:16];
    end
    d_q        <= d_d;
    res_q      <= res_d;
    lneg_q     <= lneg_d;
    phase_q    <= phase_d;
    sa_q       <= sa_d;
    sd_q       <= sd_d;
    s_q        <= s_d;
    frac_q     <= frac_d;
    q100_q     <= q100_d;
    out_data_q <= out_data_d;
  end

  tvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  tvr_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  tvr_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH),
    .IW    (IW)
  ) u_rom (
    .addr_a_i (rom_a),
    .addr_b_i (rom_b),
    .data_a_o (rom_da),
    .data_b_o (rom_db)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- rtl/tvr_checker.sv -----
`timescale 1ns / 1ps

module tvr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only one request is processed at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A new result only appears at the end of processing, while input was blocked.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a request in flight");

endmodule

bind timed_value_ramp_with_easing tvr_checker u_tvr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tvr_pkg::*;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 120;

  class ramp_scoreboard;
    bit          precision;
    bit   [15:0] ramp_ms;
    bit   [7:0]  frame_ms;
    int          start_v, cur_v, tgt_v;
    bit   [31:0] deadline;
    bit   [1:0]  curve;
    longint      sine_tab[TableDepth + 1];
    bit   [31:0] expected_results[$];
    int          mismatches, checked, ticks, snaps, sine_ticks;

    function void build_table();
      longint unsigned x, x2, term;
      longint          sum;
      for (int i = 0; i <= TableDepth; i++) begin
        x = (PiQ30 * i) / (2 * TableDepth);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 8192) / 16384;
        if (sum > 65536) sum = 65536;
        sine_tab[i] = sum;
      end
    endfunction

    function void reset_state();
      precision = 0;
      ramp_ms = 1000;
      frame_ms = 20;
      start_v = 0;
      cur_v = 0;
      tgt_v = 0;
      deadline = 0;
      curve = CURVE_LINEAR;
      build_table();
    endfunction

    function void write_reg(cfg_idx_e idx, bit [15:0] data);
      case (idx)
        CFG_PRECISION: precision = data[0];
        CFG_RAMP:      ramp_ms = data;
        CFG_FRAME:     frame_ms = data[7:0];
        default: ;
      endcase
    endfunction

    function longint sine_at(longint unsigned phase);
      longint unsigned pos, idx, frac;
      longint          a, b;
      pos = phase * TableDepth;
      idx = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= TableDepth) return sine_tab[TableDepth];
      a = sine_tab[idx];
      b = sine_tab[idx + 1];
      return a + ((b - a) * longint'(frac)) / 65536;
    endfunction

    function longint eased_delta(longint diff, longint s);
      longint p;
      p = diff * s;
      return (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
    endfunction

    function int scaled(bit [15:0] raw);
      int v;
      v = int'($signed(raw));
      return precision ? v * 100 : v;
    endfunction

    // Advances the ramp state for one accepted request and queues its result.
    function void note_request(bit [1:0] fn, bit [15:0] nv, bit [1:0] sel, bit [31:0] now);
      bit [31:0]       rem, result;
      longint unsigned d, phase;
      longint          diff, step;
      int              v;
      result = 0;
      if (fn == FUNC_SET) begin
        if (sel != CURVE_KEEP) curve = sel;
        start_v = cur_v;
        tgt_v = scaled(nv);
        deadline = now + ramp_ms;
      end else if (fn == FUNC_JUMP) begin
        v = scaled(nv);
        start_v = v;
        cur_v = v;
        tgt_v = v;
      end else if (fn == FUNC_TICK && tgt_v != cur_v) begin
        ticks++;
        rem = deadline - now - frame_ms;
        if (rem == 0 || rem[31]) begin
          cur_v = tgt_v;
          result = 1;
          snaps++;
        end else begin
          d = longint'(rem) + frame_ms;
          result = (rem > 32'hFFFF) ? 32'hFFFF : rem;
          if (curve == CURVE_EASE_OUT || curve == CURVE_EASE_IN) begin
            sine_ticks++;
            diff = longint'(tgt_v) - start_v;
            if (ramp_ms == 0 || d >= ramp_ms) phase = 65536;
            else phase = (d << 16) / ramp_ms;
            if (curve == CURVE_EASE_OUT)
              cur_v = int'(start_v + eased_delta(diff, sine_at(65536 - phase)));
            else
              cur_v = int'(tgt_v - eased_delta(diff, sine_at(phase)));
          end else begin
            step = (longint'(frame_ms) * (longint'(tgt_v) - cur_v)) / longint'(d);
            cur_v = int'(cur_v + step);
          end
        end
      end
      v = precision ? cur_v / 100 : cur_v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      expected_results.push_back({v[15:0], result[15:0]});
    endfunction

    function void check_result(bit [31:0] got);
      bit [31:0] want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: remaining_ms exp %0d got %0d, value exp %0d got %0d",
                   checked, want[15:0], got[15:0], $signed(want[31:16]),
                   $signed(got[31:16]));
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ramp_scoreboard ramp_sb;
  bit          idle_en;
  int          sent_cnt;
  bit          hold_done;
  bit   [31:0] clock_ms;

  timed_value_ramp_with_easing DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(bit [1:0] fn, bit [15:0] nv, bit [1:0] sel, bit [31:0] now);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, nv};
    s_axis_tuser <= {sel, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    ramp_sb.note_request(fn, nv, sel, now);
    sent_cnt++;
  endtask

  // The caller drops cfg_valid_i after the last write of a group.
  task automatic write_reg(cfg_idx_e idx, bit [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ramp_sb.write_reg(idx, data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ramp_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(bit prec, bit [15:0] ramp, bit [7:0] frame);
    drain();
    write_reg(CFG_PRECISION, {15'd0, prec});
    write_reg(CFG_RAMP, ramp);
    write_reg(CFG_FRAME, {8'd0, frame});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic bit [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // One ramp: an optional jump, a set with a random curve, then ticks mostly a
  // frame apart, some 0 to 3 ms apart, some skipping near or past the deadline.
  task automatic run_ramp();
    int n;
    if ($urandom_range(0, 2) == 0)
      send_request(FUNC_JUMP, pick_value(), 2'($urandom()), clock_ms);
    send_request(FUNC_SET, pick_value(), 2'($urandom()), clock_ms);
    n = $urandom_range(2, 10);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0: clock_ms += ramp_sb.ramp_ms - ramp_sb.frame_ms + $urandom_range(0, 3);
        1: clock_ms += $urandom_range(0, 3);
        default: clock_ms += ramp_sb.frame_ms;
      endcase
      send_request(FUNC_TICK, 16'($urandom()), 2'($urandom()), clock_ms);
    end
  endtask

  task automatic random_block(int count);
    int target;
    target = sent_cnt + count;
    while (sent_cnt < target) begin
      if (sent_cnt > 400) idle_en = 0;
      if ($urandom_range(0, 6) == 0)
        send_request(2'($urandom()), 16'($urandom()), 2'($urandom()), $urandom());
      else
        run_ramp();
    end
  endtask

  // Receiver: random stalls, one long hold-off, result checking.
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) ramp_sb.check_result(m_axis_tdata);
      if (!hold_done && sent_cnt >= 120) begin
        hold_done = 1;
        stall_cnt = 400;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("timeout: no request moved for %0d cycles", StallLimit);
        $display("timed_value_ramp_with_easing regression: fail");
        $finish;
      end
    end
  end

  initial begin
    ramp_sb = new();
    ramp_sb.reset_state();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    idle_en = 1;
    clock_ms = $urandom();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, value extremes, every curve and command.
    send_request(FUNC_TICK, 16'h0000, CURVE_KEEP, 32'h0000_0000);
    send_request(FUNC_JUMP, 16'h7FFF, CURVE_KEEP, clock_ms);
    send_request(FUNC_SET, 16'h8000, CURVE_KEEP, clock_ms);
    send_request(FUNC_TICK, 16'hFFFF, CURVE_EASE_IN, clock_ms + 20);
    for (int c = CURVE_LINEAR; c <= CURVE_EASE_IN; c++) begin
      send_request(FUNC_SET, 16'h7FFF, c[1:0], clock_ms);
      send_request(FUNC_TICK, 16'h0, CURVE_KEEP, clock_ms + 40);
    end
    // Unused command leaves the ramp alone.
    send_request(FUNC_NONE, 16'h1234, CURVE_EASE_OUT, 32'hFFFF_FFFF);
    // Time going backwards makes the remaining time saturate.
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, clock_ms - 32'd100000);
    // Past the deadline the value snaps to the target.
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, clock_ms + 32'd5000);
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, clock_ms + 32'd5020);
    // Deadline wrapping past 2^32.
    send_request(FUNC_SET, 16'h8000, CURVE_LINEAR, 32'hFFFF_FF00);
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, 32'hFFFF_FFF0);
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, 32'h0000_0010);

    // A ramp left running while precision mode turns on.
    apply_settings(1'b0, 16'd1000, 8'd20);
    send_request(FUNC_SET, 16'h4000, CURVE_EASE_OUT, clock_ms);
    apply_settings(1'b1, 16'd1000, 8'd20);
    send_request(FUNC_TICK, 16'h0, CURVE_KEEP, clock_ms + 20);
    send_request(FUNC_JUMP, 16'h8000, CURVE_KEEP, clock_ms);

    random_block(60);
    apply_settings(1'b0, 16'd1, 8'd1);
    random_block(60);
    apply_settings(1'b1, 16'd65535, 8'd255);
    random_block(60);
    apply_settings(1'b0, 16'd340, 8'd17);
    random_block(80);
    apply_settings(1'b1, 16'd50, 8'd20);
    random_block(60);
    apply_settings(1'b0, 16'd1000, 8'd20);
    random_block(110);
    drain();

    $display("covered %0d requests over six settings: %0d active ticks, %0d sine, %0d snaps",
             sent_cnt, ramp_sb.ticks, ramp_sb.sine_ticks, ramp_sb.snaps);
    $display("%0d results checked, %0d mismatches", ramp_sb.checked, ramp_sb.mismatches);
    if (ramp_sb.mismatches == 0 && ramp_sb.expected_results.size() == 0) begin
      $display("timed_value_ramp_with_easing regression: pass");
    end else begin
      $display("timed_value_ramp_with_easing regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tvr_pkg.sv
rtl/tvr_div.sv
rtl/tvr_mul.sv
rtl/tvr_sine_rom.sv
rtl/timed_value_ramp_with_easing.sv
rtl/tvr_checker.sv
test/tb.sv
